// ----- hw/rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int ID_W   = 14;
  localparam int REQ_W  = 3;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } action_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds a key and an id, compares its key with
// the incoming key, and takes the new entry or a neighbor's entry on command.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int KEY_BITS = 3
) (
  input  logic                     clk,
  input  spq_pkg::cell_ctrl_t      ctrl,
  input  logic                     occ,
  input  logic [KEY_BITS-1:0]      new_key,
  input  logic [spq_pkg::ID_W-1:0] new_id,
  input  logic                     ge_prev,
  input  logic [KEY_BITS-1:0]      prev_key,
  input  logic [spq_pkg::ID_W-1:0] prev_id,
  input  logic [KEY_BITS-1:0]      next_key,
  input  logic [spq_pkg::ID_W-1:0] next_id,
  output logic                     ge,
  output logic [KEY_BITS-1:0]      key,
  output logic [spq_pkg::ID_W-1:0] id
);

  // Stored entries ahead of the new one keep their place (ties stay ahead).
  assign ge = occ && (key >= new_key);

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (!ge) begin
        if (ge_prev) begin
          key <= new_key;
          id  <= new_id;
        end else begin
          key <= prev_key;
          id  <= prev_id;
        end
      end
    end else if (ctrl.rem) begin
      key <= next_key;
      id  <= next_id;
    end
  end

endmodule

// ----- hw/rtl/sorted_priority_queue_core.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Bounded priority queue kept sorted in a chain of cells, highest key first,
// first-come order among equal keys.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid/in_ready, action, priority_req,  | to block
//          | vehicle_id                                |
//  out     | out_valid/out_ready, status, out_priority,| from block
//          | out_vehicle_id, occupancy                 |
//
// Every cell compares and shifts in parallel, and the result sits in an
// output register in the cycle after acceptance.
// A new word is taken while the output register is empty or being drained,
// so back-to-back words flow at one per cycle with out_ready high.
// A stall on out holds the result and drops in_ready.
// Reset clears the fill count and the output valid; slot contents are
// meaningless until written and are never read beyond the fill count.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core #(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 3
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       action,
  input  logic [spq_pkg::REQ_W-1:0]  priority_req,
  input  logic [spq_pkg::ID_W-1:0]   vehicle_id,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [spq_pkg::STAT_W-1:0] status,
  output logic [spq_pkg::REQ_W-1:0]  out_priority,
  output logic [spq_pkg::ID_W-1:0]   out_vehicle_id,
  output logic [spq_pkg::OCC_W-1:0]  occupancy
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  logic                     accept;
  logic                     is_full;
  logic                     is_empty;
  logic [KEY_BITS-1:0]      new_key;
  spq_pkg::cell_ctrl_t      ctrl;
  spq_pkg::status_t         stat_next;
  logic [DEPTH-1:0]         occ;
  logic [DEPTH-1:0]         ge;
  logic [KEY_BITS-1:0]      keys [DEPTH];
  logic [spq_pkg::ID_W-1:0] ids  [DEPTH];

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_full  = (count == CW'(DEPTH));
  assign is_empty = (count == '0);
  assign new_key  = KEY_BITS'(priority_req);

  always_comb begin
    ctrl       = '0;
    count_next = count;
    stat_next  = spq_pkg::ST_INSERTED;
    if (action == spq_pkg::ACT_INSERT) begin
      if (is_full) begin
        stat_next = spq_pkg::ST_FULL;
      end else begin
        ctrl.ins   = accept;
        count_next = count + 1'b1;
      end
    end else begin
      if (is_empty) begin
        stat_next = spq_pkg::ST_EMPTY;
      end else begin
        stat_next  = spq_pkg::ST_REMOVED;
        ctrl.rem   = accept;
        count_next = count - 1'b1;
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      localparam int PREV = (g == 0) ? 0 : g - 1;
      localparam int NEXT = (g == DEPTH - 1) ? g : g + 1;

      assign occ[g] = (CW'(g) < count);

      spq_cell #(
        .KEY_BITS (KEY_BITS)
      ) u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .occ      (occ[g]),
        .new_key  (new_key),
        .new_id   (vehicle_id),
        .ge_prev  ((g == 0) ? 1'b1 : ge[PREV]),
        .prev_key (keys[PREV]),
        .prev_id  (ids[PREV]),
        .next_key (keys[NEXT]),
        .next_id  (ids[NEXT]),
        .ge       (ge[g]),
        .key      (keys[g]),
        .id       (ids[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload: load with the word, hold while stalled.
  always_ff @(posedge clk) begin
    if (accept) begin
      status    <= stat_next;
      occupancy <= spq_pkg::OCC_W'(count_next);
      if (stat_next == spq_pkg::ST_REMOVED) begin
        out_priority   <= spq_pkg::REQ_W'(keys[0]);
        out_vehicle_id <= ids[0];
      end else begin
        out_priority   <= '0;
        out_vehicle_id <= '0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count exceeds depth");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("word taken while result stalled");

  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    (accept && action == spq_pkg::ACT_INSERT && is_full)
      |=> (status == spq_pkg::ST_FULL && $stable(count)))
    else $error("insert on full queue not rejected");

  a_remove_count: assert property (@(posedge clk) disable iff (rst)
    (accept && action == spq_pkg::ACT_REMOVE && !is_empty)
      |=> (count == $past(count) - 1'b1 && status == spq_pkg::ST_REMOVED))
    else $error("remove did not shrink queue");

  a_sorted_head: assert property (@(posedge clk) disable iff (rst)
    occ[1] |-> (keys[0] >= keys[1]))
    else $error("head entry out of order");

endmodule
